// ===== sv/pgl_pkg.sv =====
`timescale 1ns / 1ps

package pgl_pkg;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int ID_W   = 2;
  localparam int POS_W  = 17;
  localparam int CHAN_W = 8;
  localparam int STAT_W = 2;

  // parameter defaults
  localparam int NUM_PALETTES_DEF  = 4;
  localparam int PALETTE_DEPTH_DEF = 16;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   palette_id;
    logic [POS_W-1:0]  position;
    logic [CHAN_W-1:0] new_red;
    logic [CHAN_W-1:0] new_green;
    logic [CHAN_W-1:0] new_blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;           // capture the input transfer
    logic scale;          // scale position, register entry indexes and fraction
    logic rd_lo;          // read lower entry
    logic rd_hi;          // read upper entry, keep lower one
    logic finish_simple;  // append / clear / no-op / empty lookup result
    logic finish_blend;   // blended lookup result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lookup_go;  // lookup on a palette that holds entries
    logic out_free;   // output register can take a result this cycle
  } ctrl_stat_t;

endpackage

// ===== sv/pgl_ctrl.sv =====
`timescale 1ns / 1ps

module pgl_ctrl import pgl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_RD_LO = 5'b00100,
    S_RD_HI = 5'b01000,
    S_BLEND = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.lookup_go) begin
          cmd_o.scale = 1'b1;
          state_d     = S_RD_LO;
        end else if (stat_i.out_free) begin
          cmd_o.finish_simple = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_BLEND;
      end
      S_BLEND: begin
        if (stat_i.out_free) begin
          cmd_o.finish_blend = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/pgl_datapath.sv =====
`timescale 1ns / 1ps

module pgl_datapath import pgl_pkg::*; #(
  parameter int NUM_PALETTES  = NUM_PALETTES_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  localparam int IDX_W   = $clog2(PALETTE_DEPTH);
  localparam int CNT_W   = $clog2(PALETTE_DEPTH + 1);
  localparam int PID_W   = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
  localparam int ENTRIES = NUM_PALETTES * PALETTE_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int PC_W    = (FRACTION_BITS + 1 < POS_W) ? FRACTION_BITS + 1 : POS_W;
  localparam int PP_W    = PC_W + IDX_W;
  localparam int PX_W    = (PP_W > FRACTION_BITS + IDX_W) ? PP_W : FRACTION_BITS + IDX_W;
  localparam int CMP_W   = (POS_W > FRACTION_BITS + 1) ? POS_W : FRACTION_BITS + 1;
  localparam int COL_W   = 3 * CHAN_W;
  localparam logic [CMP_W-1:0] ONE_C = {{(CMP_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  // floor(a + (b - a) * f / 2^FRACTION_BITS)
  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [FRACTION_BITS-1:0] f);
    logic signed [CHAN_W:0]                 diff;
    logic signed [FRACTION_BITS+CHAN_W+1:0] prod;
    logic signed [FRACTION_BITS+CHAN_W+1:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    acc  = $signed({2'b00, a, {FRACTION_BITS{1'b0}}}) + prod;
    return acc[FRACTION_BITS +: CHAN_W];
  endfunction

  // captured item
  op_e               op_q;
  logic [ID_W-1:0]   pid_q;
  logic [POS_W-1:0]  pos_q;
  logic [COL_W-1:0]  color_q;

  // lookup intermediates
  logic [IDX_W-1:0]         lo_q, hi_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [COL_W-1:0]         c_lo_q;

  logic [CNT_W-1:0] counts_q [NUM_PALETTES];
  logic [COL_W-1:0] mem_q [ENTRIES];
  logic [COL_W-1:0] rdata_q;

  logic      out_valid_q;
  out_item_t out_item_q;

  logic                     id_ok;
  logic [PID_W-1:0]         pid_idx;
  logic [CNT_W-1:0]         cnt_cur;
  logic                     full;
  logic [IDX_W-1:0]         cnt_m1;
  logic [CMP_W-1:0]         pos_ext;
  logic [PC_W-1:0]          pos_c;
  logic [PP_W-1:0]          prod;
  logic [PX_W-1:0]          p_x;
  logic [IDX_W-1:0]         lo_d, hi_d;
  logic [FRACTION_BITS-1:0] frac_d;
  logic [ADDR_W-1:0]        base;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic                     append_ok;
  stat_e                    simple_stat;

  assign id_ok   = (32'(pid_q) < 32'(NUM_PALETTES));
  assign pid_idx = PID_W'(pid_q);
  assign cnt_cur = id_ok ? counts_q[pid_idx] : '0;
  assign full    = (cnt_cur == CNT_W'(PALETTE_DEPTH));
  assign cnt_m1  = IDX_W'(cnt_cur - CNT_W'(1));

  // clamp to 1.0 and scale by count - 1
  assign pos_ext = CMP_W'(pos_q);
  assign pos_c   = PC_W'((pos_ext > ONE_C) ? ONE_C : pos_ext);
  assign prod    = PP_W'(pos_c) * PP_W'(cnt_m1);
  assign p_x     = PX_W'(prod);
  assign lo_d    = p_x[FRACTION_BITS +: IDX_W];
  assign frac_d  = p_x[FRACTION_BITS-1:0];
  assign hi_d    = (frac_d != '0) ? IDX_W'(lo_d + IDX_W'(1)) : lo_d;

  assign base  = ADDR_W'(ADDR_W'(pid_idx) * ADDR_W'(PALETTE_DEPTH));
  assign waddr = ADDR_W'(base + ADDR_W'(cnt_cur));
  assign raddr = ADDR_W'(base + ADDR_W'(cmd_i.rd_lo ? lo_q : hi_q));

  assign append_ok = (op_q == OP_APPEND) && id_ok && !full;

  always_comb begin
    case (op_q)
      OP_LOOKUP: simple_stat = ST_EMPTY;
      OP_APPEND: simple_stat = append_ok ? ST_OK : ST_FULL;
      OP_CLEAR:  simple_stat = ST_OK;
      OP_NOP:    simple_stat = ST_OK;
      default:   simple_stat = ST_OK;
    endcase
  end

  assign stat_o.lookup_go = (op_q == OP_LOOKUP) && (cnt_cur != '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(in_item_i.opcode);
      pid_q   <= in_item_i.palette_id;
      pos_q   <= in_item_i.position;
      color_q <= {in_item_i.new_red, in_item_i.new_green, in_item_i.new_blue};
    end
    if (cmd_i.scale) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      frac_q <= frac_d;
    end
    if (cmd_i.rd_hi) begin
      c_lo_q <= rdata_q;
    end
  end

  // color memory, one port each way
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_simple && append_ok) begin
      mem_q[waddr] <= color_q;
    end
    if (cmd_i.rd_lo || cmd_i.rd_hi) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PALETTES; i++) begin
        counts_q[i] <= '0;
      end
    end else if (cmd_i.finish_simple && id_ok) begin
      if (append_ok) begin
        counts_q[pid_idx] <= CNT_W'(cnt_cur + CNT_W'(1));
      end else if (op_q == OP_CLEAR) begin
        counts_q[pid_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish_simple || cmd_i.finish_blend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_simple) begin
      out_item_q.out_red   <= '0;
      out_item_q.out_green <= '0;
      out_item_q.out_blue  <= '0;
      out_item_q.status    <= simple_stat;
    end else if (cmd_i.finish_blend) begin
      out_item_q.out_red   <= blend(c_lo_q[23:16], rdata_q[23:16], frac_q);
      out_item_q.out_green <= blend(c_lo_q[15:8], rdata_q[15:8], frac_q);
      out_item_q.out_blue  <= blend(c_lo_q[7:0], rdata_q[7:0], frac_q);
      out_item_q.status    <= ST_OK;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== sv/palette_gradient_lookup.sv =====
`timescale 1ns / 1ps

// palette_gradient_lookup: a set of rgb palettes with append, clear and a
// gradient lookup that blends the two entries nearest a q-format position
// - input channel in_valid_i / in_ready_o carries one operation per transfer
// - output channel out_valid_o / out_ready_i returns exactly one result per
//   operation, in order; status tells ok, empty palette or full palette
// - one operation at a time: in_ready_o is high only while the controller idles
// - append, clear, no-op and empty lookups: result registered in the execute
//   step once the output register is free, next input taken after that step
// - lookups: a scale multiply, then two reads through the single read port
//   of the color memory ahead of the blend; next input taken after the blend
// - the output register decouples the sides: a new input is taken while a
//   result still waits; the finishing step holds until that result is taken
// - reset clears the entry counts, so every palette starts empty; the color
//   memory itself is not cleared and needs no sweep
module palette_gradient_lookup import pgl_pkg::*; #(
  parameter int NUM_PALETTES  = NUM_PALETTES_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencing of one operation
  pgl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // counts, color memory, scale and blend arithmetic, output register
  pgl_datapath #(
    .NUM_PALETTES  (NUM_PALETTES),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
